### rtl/core/bgrt_pkg.sv
`default_nettype none

package bgrt_pkg;

	// Map geometry
	localparam int MAP_SIDE  = 256;
	localparam int MAP_WORDS = 65536;
	localparam int ADDR_W    = $clog2(MAP_WORDS);
	localparam int CELL_W    = $clog2(MAP_SIDE);
	localparam int SIDE_W    = CELL_W + 1;

	// Opcodes
	localparam logic [1:0] OP_WR    = 2'd0;
	localparam logic [1:0] OP_RD    = 2'd1;
	localparam logic [1:0] OP_FWD   = 2'd2;
	localparam logic [1:0] OP_TRANS = 2'd3;

	// Status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_OFF  = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_WIDTH    = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_SCALE_X  = 3'd2;
	localparam logic [2:0] REG_SCALE_Y  = 3'd3;
	localparam logic [2:0] REG_OFFSET_X = 3'd4;
	localparam logic [2:0] REG_OFFSET_Y = 3'd5;
	localparam logic [2:0] REG_GAIN     = 3'd6;
	localparam logic [2:0] REG_WRAP     = 3'd7;

	// Geometry settings seen by the coordinate unit
	typedef struct packed {
		logic [SIDE_W-1:0]  width;
		logic [SIDE_W-1:0]  height;
		logic [31:0]        scale_x;
		logic [31:0]        scale_y;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic               wrap;
	} cfg_t;

	// Resolved neighborhood of one point
	typedef struct packed {
		logic [1:0]              status;
		logic [3:0][ADDR_W-1:0]  addr;
		logic [3:0][32:0]        wt;
	} coord_res_t;

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [SIDE_W-1:0] clamp_size(input logic [SIDE_W-1:0] n);
		logic [SIDE_W-1:0] r;
		if (n < SIDE_W'(2)) begin
			r = SIDE_W'(2);
		end else if (n > SIDE_W'(MAP_SIDE)) begin
			r = SIDE_W'(MAP_SIDE);
		end else begin
			r = n;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/bgrt_map_ram.sv
`default_nettype none

// Single-port synchronous RAM, registered read
module bgrt_map_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/bgrt_coord.sv
`default_nettype none

// Maps a point to its four map neighbors: scale, offset, split, optional
// wrap through a bit-serial remainder, then addresses and bilinear weights.
module bgrt_coord (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [31:0]  point_x,
	input  wire logic signed [31:0]  point_y,
	input  wire bgrt_pkg::cfg_t      cfg,
	output logic                     busy,
	output bgrt_pkg::coord_res_t     res
);

	localparam int SW = bgrt_pkg::SIDE_W;
	localparam int CW = bgrt_pkg::CELL_W;
	localparam int AW = bgrt_pkg::ADDR_W;

	localparam logic [2:0] C_IDLE  = 3'd0;
	localparam logic [2:0] C_MUL   = 3'd1;
	localparam logic [2:0] C_SPLIT = 3'd2;
	localparam logic [2:0] C_DIV   = 3'd3;
	localparam logic [2:0] C_FIN   = 3'd4;

	logic [2:0]           state_q;
	logic signed [31:0]   px_q, py_q;
	logic signed [64:0]   prod_x_q, prod_y_q;
	logic signed [33:0]   cx_q, cy_q;
	logic [15:0]          fx_q, fy_q;
	logic [32:0]          magx_q, magy_q;
	logic                 negx_q, negy_q;
	logic [SW-1:0]        remx_q, remy_q;
	logic [5:0]           cnt_q;
	bgrt_pkg::coord_res_t res_q;

	logic [SW-1:0]        w, h;
	logic signed [64:0]   ux, uy;
	logic signed [33:0]   cxw, cyw, cxn, cyn;
	logic [SW:0]          rrx, rry;
	logic [SW-1:0]        nxt_remx, nxt_remy;

	// Finish-stage signals
	logic [SW-1:0]        wcx, wcy;
	logic [CW-1:0]        x0, x1, y0, y1;
	logic [1:0]           stx, sty;
	logic signed [33:0]   wm1, hm1;
	logic [16:0]          gx, gy, fxe, fye;
	logic [AW:0]          yb0, yb1;
	bgrt_pkg::coord_res_t fin;

	assign w    = bgrt_pkg::clamp_size(cfg.width);
	assign h    = bgrt_pkg::clamp_size(cfg.height);
	assign busy = (state_q != C_IDLE);
	assign res  = res_q;

	// Grid position: floor(point*scale / 2^16) + offset
	assign ux  = (prod_x_q >>> 16) + $signed({{33{cfg.offset_x[31]}}, cfg.offset_x});
	assign uy  = (prod_y_q >>> 16) + $signed({{33{cfg.offset_y[31]}}, cfg.offset_y});
	assign cxw = ux[49:16];
	assign cyw = uy[49:16];
	assign cxn = -cxw;
	assign cyn = -cyw;

	// One remainder bit per cycle
	assign rrx      = {remx_q, magx_q[32]};
	assign rry      = {remy_q, magy_q[32]};
	assign nxt_remx = (rrx >= {1'b0, w}) ? SW'(rrx - {1'b0, w}) : rrx[SW-1:0];
	assign nxt_remy = (rry >= {1'b0, h}) ? SW'(rry - {1'b0, h}) : rry[SW-1:0];

	// Cells, status, addresses and weights
	always_comb begin
		wcx = (negx_q && remx_q != '0) ? SW'(w - remx_q) : remx_q;
		wcy = (negy_q && remy_q != '0) ? SW'(h - remy_q) : remy_q;
		x0  = cfg.wrap ? wcx[CW-1:0] : cx_q[CW-1:0];
		y0  = cfg.wrap ? wcy[CW-1:0] : cy_q[CW-1:0];
		x1  = ({1'b0, x0} == SW'(w - SW'(1))) ? '0 : CW'(x0 + CW'(1));
		y1  = ({1'b0, y0} == SW'(h - SW'(1))) ? '0 : CW'(y0 + CW'(1));
		wm1 = $signed({{(34-SW){1'b0}}, SW'(w - SW'(1))});
		hm1 = $signed({{(34-SW){1'b0}}, SW'(h - SW'(1))});

		if (cfg.wrap || (!cx_q[33] && cx_q < wm1)) begin
			stx = bgrt_pkg::ST_DONE;
		end else if (cx_q == wm1) begin
			stx = bgrt_pkg::ST_SKIP;
		end else begin
			stx = bgrt_pkg::ST_OFF;
		end
		if (cfg.wrap || (!cy_q[33] && cy_q < hm1)) begin
			sty = bgrt_pkg::ST_DONE;
		end else if (cy_q == hm1) begin
			sty = bgrt_pkg::ST_SKIP;
		end else begin
			sty = bgrt_pkg::ST_OFF;
		end

		yb0 = (AW+1)'(y0 * w);
		yb1 = (AW+1)'(y1 * w);
		fxe = {1'b0, fx_q};
		fye = {1'b0, fy_q};
		gx  = 17'h10000 - fxe;
		gy  = 17'h10000 - fye;

		fin.status  = (sty != bgrt_pkg::ST_DONE) ? sty : stx;
		fin.addr[0] = AW'(yb0 + (AW+1)'(x0));
		fin.addr[1] = AW'(yb0 + (AW+1)'(x1));
		fin.addr[2] = AW'(yb1 + (AW+1)'(x0));
		fin.addr[3] = AW'(yb1 + (AW+1)'(x1));
		fin.wt[0]   = 33'(gx * gy);
		fin.wt[1]   = 33'(fxe * gy);
		fin.wt[2]   = 33'(gx * fye);
		fin.wt[3]   = 33'(fxe * fye);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) state_q <= C_MUL;
				end
				C_MUL: begin
					state_q <= C_SPLIT;
				end
				C_SPLIT: begin
					cnt_q   <= '0;
					state_q <= cfg.wrap ? C_DIV : C_FIN;
				end
				C_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) state_q <= C_FIN;
				end
				C_FIN: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					px_q <= point_x;
					py_q <= point_y;
				end
			end
			C_MUL: begin
				prod_x_q <= px_q * $signed({1'b0, cfg.scale_x});
				prod_y_q <= py_q * $signed({1'b0, cfg.scale_y});
			end
			C_SPLIT: begin
				cx_q   <= cxw;
				cy_q   <= cyw;
				fx_q   <= ux[15:0];
				fy_q   <= uy[15:0];
				negx_q <= cxw[33];
				negy_q <= cyw[33];
				magx_q <= cxw[33] ? cxn[32:0] : cxw[32:0];
				magy_q <= cyw[33] ? cyn[32:0] : cyw[32:0];
				remx_q <= '0;
				remy_q <= '0;
			end
			C_DIV: begin
				remx_q <= nxt_remx;
				remy_q <= nxt_remy;
				magx_q <= {magx_q[31:0], 1'b0};
				magy_q <= {magy_q[31:0], 1'b0};
			end
			C_FIN: begin
				res_q <= fin;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/bilinear_grid_ray_trace_top.sv
`default_nettype none

// Bilinear map trace engine. A 2-D map of Q16.16 samples (up to 256 x 256)
// sits in a single-port RAM and is loaded and read back by word. Forward
// items return phi + gain * bilinear sample; transpose items scatter-add
// gain * phi * weight into the four neighbor cells with 32-bit saturation.
// The four neighbor accesses of a trace go one at a time through the single
// RAM port (read, multiply, accumulate or write back), and wrap adds a
// 33-step bit-serial remainder for the cell index. An item is taken whenever
// the engine is idle, even while the previous result is still held in the
// output register.
module bilinear_grid_ray_trace_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Input transaction
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic [15:0]        map_index,
	input  wire logic signed [31:0] map_value,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] phi_value,
	// Output transaction
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      result_value,
	output logic [1:0]              status,
	// Register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int SW = bgrt_pkg::SIDE_W;
	localparam int AW = bgrt_pkg::ADDR_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MAPRD = 4'd1;
	localparam logic [3:0] S_GAIN1 = 4'd2;
	localparam logic [3:0] S_GAIN2 = 4'd3;
	localparam logic [3:0] S_WAITC = 4'd4;
	localparam logic [3:0] S_RD    = 4'd5;
	localparam logic [3:0] S_CAP   = 4'd6;
	localparam logic [3:0] S_UPD   = 4'd7;
	localparam logic [3:0] S_BIL   = 4'd8;
	localparam logic [3:0] S_GMUL  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	// Registers
	logic [SW-1:0]      width_q, height_q;
	logic [31:0]        scale_x_q, scale_y_q;
	logic signed [31:0] offset_x_q, offset_y_q, gain_q;
	logic               wrap_q;
	logic               cfg_wr;
	bgrt_pkg::cfg_t     cfg;

	// Engine
	logic [3:0]         state_q;
	logic [1:0]         op_q, k_q;
	logic signed [31:0] phi_q, t_q, res_q;
	logic [1:0]         stat_q;
	logic signed [63:0] gp_q;
	logic signed [65:0] prod_q, acc_q, gb_q;
	logic signed [33:0] bil_q;
	logic               out_valid_q;
	logic signed [31:0] out_res_q;
	logic [1:0]         out_stat_q;

	logic               in_acc, out_free, fwd;
	logic               cstart, cbusy;
	bgrt_pkg::coord_res_t cres;

	logic               mem_en, mem_we;
	logic [AW-1:0]      mem_addr;
	logic [31:0]        mem_wdata, mem_rdata;

	logic signed [31:0] mul_a;
	logic signed [65:0] gpr, delta_r, upd_sum, bil_r, term_r, fin_sum;
	logic signed [31:0] upd_val;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign fwd      = (op_q == bgrt_pkg::OP_FWD);
	assign cstart   = in_acc && (opcode == bgrt_pkg::OP_FWD || opcode == bgrt_pkg::OP_TRANS);

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign status       = out_stat_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= SW'(256);
			height_q   <= SW'(256);
			scale_x_q  <= 32'd65536;
			scale_y_q  <= 32'd65536;
			offset_x_q <= '0;
			offset_y_q <= '0;
			gain_q     <= 32'sd65536;
			wrap_q     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				bgrt_pkg::REG_WIDTH:    width_q    <= pwdata[SW-1:0];
				bgrt_pkg::REG_HEIGHT:   height_q   <= pwdata[SW-1:0];
				bgrt_pkg::REG_SCALE_X:  scale_x_q  <= pwdata;
				bgrt_pkg::REG_SCALE_Y:  scale_y_q  <= pwdata;
				bgrt_pkg::REG_OFFSET_X: offset_x_q <= pwdata;
				bgrt_pkg::REG_OFFSET_Y: offset_y_q <= pwdata;
				bgrt_pkg::REG_GAIN:     gain_q     <= pwdata;
				bgrt_pkg::REG_WRAP:     wrap_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[4:2])
			bgrt_pkg::REG_WIDTH:    prdata = {{(32-SW){1'b0}}, width_q};
			bgrt_pkg::REG_HEIGHT:   prdata = {{(32-SW){1'b0}}, height_q};
			bgrt_pkg::REG_SCALE_X:  prdata = scale_x_q;
			bgrt_pkg::REG_SCALE_Y:  prdata = scale_y_q;
			bgrt_pkg::REG_OFFSET_X: prdata = offset_x_q;
			bgrt_pkg::REG_OFFSET_Y: prdata = offset_y_q;
			bgrt_pkg::REG_GAIN:     prdata = gain_q;
			bgrt_pkg::REG_WRAP:     prdata = {31'd0, wrap_q};
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		cfg.width    = width_q;
		cfg.height   = height_q;
		cfg.scale_x  = scale_x_q;
		cfg.scale_y  = scale_y_q;
		cfg.offset_x = offset_x_q;
		cfg.offset_y = offset_y_q;
		cfg.wrap     = wrap_q;
	end

	bgrt_coord u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cstart),
		.point_x (point_x),
		.point_y (point_y),
		.cfg     (cfg),
		.busy    (cbusy),
		.res     (cres)
	);

	bgrt_map_ram #(
		.ADDR_W (AW),
		.DATA_W (32)
	) u_map (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Arithmetic with round half up (add half, floor)
	assign gpr     = ($signed({{2{gp_q[63]}}, gp_q}) + 66'sd32768) >>> 16;
	assign mul_a   = fwd ? $signed(mem_rdata) : t_q;
	assign delta_r = (prod_q + 66'sd2147483648) >>> 32;
	assign upd_sum = $signed({{34{mem_rdata[31]}}, mem_rdata}) + delta_r;
	assign upd_val = bgrt_pkg::sat32(upd_sum);
	assign bil_r   = (acc_q + 66'sd2147483648) >>> 32;
	assign term_r  = (gb_q + 66'sd32768) >>> 16;
	assign fin_sum = $signed({{34{phi_q[31]}}, phi_q}) + term_r;

	// RAM port
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = map_index;
		mem_wdata = map_value;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && opcode == bgrt_pkg::OP_WR) begin
					mem_en = 1'b1;
					mem_we = 1'b1;
				end else if (in_acc && opcode == bgrt_pkg::OP_RD) begin
					mem_en = 1'b1;
				end
			end
			S_RD: begin
				mem_en   = 1'b1;
				mem_addr = cres.addr[k_q];
			end
			S_UPD: begin
				if (!fwd) begin
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_addr  = cres.addr[k_q];
					mem_wdata = upd_val;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (opcode)
							bgrt_pkg::OP_WR:    state_q <= S_DONE;
							bgrt_pkg::OP_RD:    state_q <= S_MAPRD;
							bgrt_pkg::OP_FWD:   state_q <= S_GAIN1;
							bgrt_pkg::OP_TRANS: state_q <= S_GAIN1;
							default:            state_q <= S_IDLE;
						endcase
					end
				end
				S_MAPRD: state_q <= S_DONE;
				S_GAIN1: state_q <= S_GAIN2;
				S_GAIN2: state_q <= S_WAITC;
				S_WAITC: begin
					if (!cbusy) begin
						k_q     <= '0;
						state_q <= (cres.status == bgrt_pkg::ST_DONE) ? S_RD : S_DONE;
					end
				end
				S_RD:  state_q <= S_CAP;
				S_CAP: state_q <= S_UPD;
				S_UPD: begin
					k_q <= k_q + 2'd1;
					if (k_q != 2'd3) begin
						state_q <= S_RD;
					end else begin
						state_q <= fwd ? S_BIL : S_DONE;
					end
				end
				S_BIL:  state_q <= S_GMUL;
				S_GMUL: state_q <= S_FIN;
				S_FIN:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output valid: set on hand-over, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q   <= opcode;
				phi_q  <= phi_value;
				res_q  <= '0;
				stat_q <= bgrt_pkg::ST_DONE;
			end
			S_MAPRD: res_q <= mem_rdata;
			S_GAIN1: gp_q  <= gain_q * phi_q;
			S_GAIN2: t_q   <= bgrt_pkg::sat32(gpr);
			S_WAITC: begin
				acc_q  <= '0;
				stat_q <= cres.status;
				res_q  <= (fwd && cres.status != bgrt_pkg::ST_DONE) ? phi_q : 32'sd0;
			end
			S_CAP: prod_q <= mul_a * $signed({1'b0, cres.wt[k_q]});
			S_UPD: begin
				if (fwd) acc_q <= acc_q + prod_q;
			end
			S_BIL:  bil_q <= bil_r[33:0];
			S_GMUL: gb_q  <= gain_q * bil_q;
			S_FIN:  res_q <= bgrt_pkg::sat32(fin_sum);
			S_DONE: begin
				if (out_free) begin
					out_res_q  <= res_q;
					out_stat_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

	// RAM writes come only from a word write or a transpose write-back
	a_mem_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == S_UPD && op_q == bgrt_pkg::OP_TRANS) ||
		            (state_q == S_IDLE && in_acc && opcode == bgrt_pkg::OP_WR)))
		else $error("unexpected map write");

	// Neighbor accesses only after the coordinate unit has finished
	a_coord_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_CAP || state_q == S_UPD) |-> !cbusy)
		else $error("neighbor access while coordinates in flight");

	// A new result is only loaded from the hand-over state
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside hand-over");

	// The neighbor counter has wrapped once all four are done
	a_bil_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BIL) |-> (k_q == 2'd0 && fwd))
		else $error("bilinear sum taken early");

endmodule

`default_nettype wire

### bench/bilinear_grid_ray_trace_top_test.sv
`timescale 1ns / 100ps

module bilinear_grid_ray_trace_top_test;

	// Map contents and settings as the block should see them
	class trace_scoreboard;
		logic [31:0] map_words [0:bgrt_pkg::MAP_WORDS-1];
		bit written [0:bgrt_pkg::MAP_WORDS-1];
		logic [8:0] width_r, height_r;
		logic [31:0] scale_x_r, scale_y_r, offset_x_r, offset_y_r, gain_r;
		bit wrap_r;
		logic signed [31:0] exp_value [$];
		logic [1:0] exp_status [$];
		int errors, checked;

		function new();
			width_r = 256; height_r = 256; scale_x_r = 65536; scale_y_r = 65536;
			offset_x_r = 0; offset_y_r = 0; gain_r = 65536; wrap_r = 0;
			errors = 0; checked = 0;
			for (int i = 0; i < bgrt_pkg::MAP_WORDS; i++) written[i] = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				bgrt_pkg::REG_WIDTH: width_r = v[8:0];
				bgrt_pkg::REG_HEIGHT: height_r = v[8:0];
				bgrt_pkg::REG_SCALE_X: scale_x_r = v;
				bgrt_pkg::REG_SCALE_Y: scale_y_r = v;
				bgrt_pkg::REG_OFFSET_X: offset_x_r = v;
				bgrt_pkg::REG_OFFSET_Y: offset_y_r = v;
				bgrt_pkg::REG_GAIN: gain_r = v;
				bgrt_pkg::REG_WRAP: wrap_r = v[0];
			endcase
		endfunction

		// Round half up on a signed 128-bit value; >>> floors
		function longint rnd_shift(logic signed [127:0] v, int s);
			logic signed [127:0] r;
			r = (v + (128'sd1 <<< (s - 1))) >>> s;
			return longint'(r);
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function int eff_size(logic [8:0] n);
			if (n < 2) return 2;
			if (n > bgrt_pkg::MAP_SIDE) return bgrt_pkg::MAP_SIDE;
			return n;
		endfunction

		// One axis: 0 ok, 1 last line, 2 off the map
		function logic [1:0] axis(logic [31:0] p, logic [31:0] sc, logic [31:0] off,
				int n, output int c0, output int c1, output longint f);
			longint u, c;
			logic signed [127:0] prod;
			prod = $signed(p) * $signed({1'b0, sc});
			u = longint'(prod >>> 16) + longint'($signed(off));
			c = u >>> 16;
			f = u & 64'hFFFF;
			c0 = 0; c1 = 0;
			if (wrap_r) begin
				c = c % n;
				if (c < 0) c += n;
				c0 = c; c1 = (c == n - 1) ? 0 : c + 1;
				return bgrt_pkg::ST_DONE;
			end
			if (c >= 0 && c < n - 1) begin
				c0 = c; c1 = c + 1;
				return bgrt_pkg::ST_DONE;
			end
			return (c == n - 1) ? bgrt_pkg::ST_SKIP : bgrt_pkg::ST_OFF;
		endfunction

		function void note_input(logic [1:0] op, logic [15:0] idx, logic [31:0] mv,
				logic [31:0] px, logic [31:0] py, logic [31:0] phi);
			logic signed [31:0] res;
			logic [1:0] st, sy;
			int w, h, x0, x1, y0, y1;
			longint fx, fy, t, bil, term, sum;
			int a [4];
			longint wt [4];
			res = 0; st = bgrt_pkg::ST_DONE;
			if (op == bgrt_pkg::OP_WR) begin
				map_words[idx] = mv; written[idx] = 1;
			end else if (op == bgrt_pkg::OP_RD) begin
				res = map_words[idx];
			end else begin
				w = eff_size(width_r); h = eff_size(height_r);
				fx = 0;
				sy = axis(py, scale_y_r, offset_y_r, h, y0, y1, fy);
				st = sy;
				if (sy == bgrt_pkg::ST_DONE)
					st = axis(px, scale_x_r, offset_x_r, w, x0, x1, fx);
				if (st == bgrt_pkg::ST_DONE) begin
					a[0] = y0 * w + x0; wt[0] = (65536 - fx) * (65536 - fy);
					a[1] = y0 * w + x1; wt[1] = fx * (65536 - fy);
					a[2] = y1 * w + x0; wt[2] = (65536 - fx) * fy;
					a[3] = y1 * w + x1; wt[3] = fx * fy;
					if (op == bgrt_pkg::OP_FWD) begin
						sum = 0;
						for (int k = 0; k < 4; k++)
							sum += longint'($signed(map_words[a[k]])) * wt[k];
						bil = rnd_shift(sum, 32);
						term = rnd_shift(128'(longint'($signed(gain_r))) * 128'(bil), 16);
						res = clip32(longint'($signed(phi)) + term);
					end else begin
						t = clip32(rnd_shift(longint'($signed(gain_r))
							* longint'($signed(phi)), 16));
						for (int k = 0; k < 4; k++)
							map_words[a[k]] = clip32(longint'($signed(map_words[a[k]]))
								+ rnd_shift(128'(t) * 128'(wt[k]), 32));
					end
				end else if (op == bgrt_pkg::OP_FWD) begin
					res = phi;
				end
			end
			exp_value.push_back(res);
			exp_status.push_back(st);
		endfunction

		function void check_result(logic signed [31:0] v, logic [1:0] s);
			logic signed [31:0] ev;
			logic [1:0] es;
			checked++;
			if (exp_value.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result value=%0d status=%0d", v, s);
				return;
			end
			ev = exp_value.pop_front(); es = exp_status.pop_front();
			if (v !== ev || s !== es) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
						ev, v, es, s);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] opcode = 0;
	logic [15:0] map_index = 0;
	logic signed [31:0] map_value = 0, point_x = 0, point_y = 0, phi_value = 0;
	logic signed [31:0] result_value;
	logic [1:0] status;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;

	trace_scoreboard sb = new();
	int send_idle_pct = 0, stall_pct = 0, hold_off = 0;
	int hold_req = 0, hold_seen = 0;
	int traces = 0;

	bilinear_grid_ray_trace_top dut (.*);

	always #6 clk = ~clk;

	// Receiver: random or forced stalls, check each accepted transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(result_value, status);
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_off <= 300;
			out_stall <= 1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		in_valid <= 0;
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	// Offer one transaction, hold it until taken
	task automatic send_item(logic [1:0] op, logic [15:0] idx, logic [31:0] mv,
			logic [31:0] px, logic [31:0] py, logic [31:0] phi);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1; opcode <= op; map_index <= idx; map_value <= mv;
		point_x <= px; point_y <= py; phi_value <= phi;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, idx, mv, px, py, phi);
		if (op[1]) traces++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.exp_value.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Load the whole active map so no trace reads an unwritten word
	task automatic load_map();
		int w, h;
		w = sb.eff_size(sb.width_r); h = sb.eff_size(sb.height_r);
		for (int i = 0; i < w * h; i++)
			if (!sb.written[i])
				send_item(bgrt_pkg::OP_WR, 16'(i),
					$urandom_range(1) ? $urandom : $urandom_range(600000), 0, 0, 0);
	endtask

	function logic [31:0] rand_q();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0008_0000);
			2: return -$urandom_range(0, 32'h0008_0000);
			default: return {$urandom_range(20), 16'($urandom)};
		endcase
	endfunction

	task automatic random_items(int n);
		logic [1:0] op;
		int lim;
		for (int i = 0; i < n; i++) begin
			op = $urandom_range(3);
			lim = sb.eff_size(sb.width_r) * sb.eff_size(sb.height_r) - 1;
			if (op == bgrt_pkg::OP_RD || op == bgrt_pkg::OP_WR) begin
				send_item(op, (op == bgrt_pkg::OP_WR && $urandom_range(9) == 0) ? 16'($urandom)
					: $urandom_range(lim), $urandom, $urandom, $urandom, $urandom);
				if (op == bgrt_pkg::OP_WR) load_map();
			end else begin
				send_item(op, $urandom, $urandom, rand_q(), rand_q(),
					$urandom_range(3) == 0 ? $urandom : rand_q());
			end
		end
	endtask

	task automatic set_geometry(int w, int h, bit wr);
		write_reg(bgrt_pkg::REG_WIDTH, w); write_reg(bgrt_pkg::REG_HEIGHT, h);
		write_reg(bgrt_pkg::REG_WRAP, wr);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: small map, edges of fields and of the grid
		set_geometry(4, 3, 0);
		load_map();
		send_item(bgrt_pkg::OP_RD, 0, 0, 0, 0, 0);
		send_item(bgrt_pkg::OP_RD, 11, 0, 0, 0, 0);
		send_item(bgrt_pkg::OP_FWD, 0, 0, 32'h0000_8000, 32'h0000_4000, 32'h7FFF_FFFF);
		send_item(bgrt_pkg::OP_FWD, 0, 0, 32'h0002_FFFF, 32'h0001_FFFF, 32'h8000_0000);
		send_item(bgrt_pkg::OP_FWD, 0, 0, 0, 32'h0002_0000, 5);
		send_item(bgrt_pkg::OP_FWD, 0, 0, 32'h0003_0000, 0, 7);
		send_item(bgrt_pkg::OP_FWD, 0, 0, 32'hFFFF_FFFF, 0, 9);
		send_item(bgrt_pkg::OP_FWD, 0, 0, 0, 32'h8000_0000, 9);
		send_item(bgrt_pkg::OP_TRANS, 0, 0, 32'h0001_8000, 32'h0000_8000, 32'h7FFF_FFFF);
		send_item(bgrt_pkg::OP_TRANS, 0, 0, 32'h0001_8000, 32'h0000_8000, 32'h8000_0000);
		send_item(bgrt_pkg::OP_TRANS, 0, 0, 32'h0003_0000, 0, 1);
		send_item(bgrt_pkg::OP_WR, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);
		send_item(bgrt_pkg::OP_RD, 16'hFFFF, 0, 0, 0, 0);
		drain();
		set_geometry(0, 511, 1);
		write_reg(bgrt_pkg::REG_GAIN, 32'h8000_0000);
		write_reg(bgrt_pkg::REG_SCALE_X, 32'hFFFF_FFFF); write_reg(bgrt_pkg::REG_SCALE_Y, 0);
		write_reg(bgrt_pkg::REG_OFFSET_X, 32'h7FFF_FFFF);
		write_reg(bgrt_pkg::REG_OFFSET_Y, 32'h8000_0000);
		load_map();
		send_item(bgrt_pkg::OP_FWD, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
		send_item(bgrt_pkg::OP_TRANS, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
		send_item(bgrt_pkg::OP_FWD, 0, 0, 32'hFFFF_FFFF, 3, 0);
		drain();

		// Random phases over settings and idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 79; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 79; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			set_geometry($urandom_range(2, 12), $urandom_range(2, 12), ph[0]);
			write_reg(bgrt_pkg::REG_SCALE_X, $urandom_range(0, 32'h0003_0000));
			write_reg(bgrt_pkg::REG_SCALE_Y, $urandom_range(0, 32'h0003_0000));
			write_reg(bgrt_pkg::REG_OFFSET_X, $urandom_range(0, 32'h0004_0000));
			write_reg(bgrt_pkg::REG_OFFSET_Y, $urandom_range(0, 32'h0004_0000));
			write_reg(bgrt_pkg::REG_GAIN, ph == 5 ? 32'h7FFF_FFFF : rand_q());
			load_map();
			if (ph == 2) hold_req++;
			random_items(150);
			drain();
		end

		// Full-size map with wrap: every trace lands on the far corner cell
		send_idle_pct = 0; stall_pct = 0;
		set_geometry(256, 256, 1);
		write_reg(bgrt_pkg::REG_SCALE_X, 0); write_reg(bgrt_pkg::REG_SCALE_Y, 0);
		write_reg(bgrt_pkg::REG_OFFSET_X, 32'h00FF_4000);
		write_reg(bgrt_pkg::REG_OFFSET_Y, 32'h00FF_8000);
		write_reg(bgrt_pkg::REG_GAIN, 32'h0001_0000);
		send_item(bgrt_pkg::OP_WR, 16'd0, $urandom, 0, 0, 0);
		send_item(bgrt_pkg::OP_WR, 16'd255, $urandom, 0, 0, 0);
		send_item(bgrt_pkg::OP_WR, 16'd65280, $urandom, 0, 0, 0);
		send_item(bgrt_pkg::OP_WR, 16'd65535, $urandom, 0, 0, 0);
		for (int i = 0; i < 24; i++)
			send_item(i[0] ? bgrt_pkg::OP_TRANS : bgrt_pkg::OP_FWD, 0, 0,
				$urandom, $urandom, rand_q());
		send_item(bgrt_pkg::OP_RD, 16'd0, 0, 0, 0, 0);
		send_item(bgrt_pkg::OP_RD, 16'd255, 0, 0, 0, 0);
		send_item(bgrt_pkg::OP_RD, 16'd65280, 0, 0, 0, 0);
		send_item(bgrt_pkg::OP_RD, 16'd65535, 0, 0, 0, 0);
		drain();

		$display("covered word read/write, forward and transpose traces over %0d trace items,",
			traces);
		$display("wrap on/off, map sizes 2..256, %0d results checked", sb.checked);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/bgrt_pkg.sv
rtl/core/bgrt_map_ram.sv
rtl/core/bgrt_coord.sv
rtl/core/bilinear_grid_ray_trace_top.sv
bench/bilinear_grid_ray_trace_top_test.sv
